[hdl/bqc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_pkg
// Shared types and constants for the biquad cascade filter.
// ----------------------------------------------------------------------------
package bqc_pkg;

	localparam int SampleW = 24;
	localparam int ChanW   = 3;
	localparam int CoefW   = 32;
	localparam int MemW    = 48;
	localparam int ProdW   = 56;
	localparam int AccW    = 62;

	// register indexes
	localparam logic [1:0] REG_STAGE_COUNT  = 2'd0;
	localparam logic [1:0] REG_STAGE_BYPASS = 2'd1;
	localparam logic [1:0] REG_COEF_INDEX   = 2'd2;
	localparam logic [1:0] REG_COEF_VALUE   = 2'd3;

	// product selection for the shared multiplier
	typedef enum logic [2:0] {
		TAP_B0 = 3'd0,
		TAP_B1 = 3'd1,
		TAP_B2 = 3'd2,
		TAP_A1 = 3'd3,
		TAP_A2 = 3'd4
	} tap_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_RD,
		ST_B0,
		ST_Y,
		ST_B1,
		ST_A1,
		ST_M1,
		ST_B2,
		ST_A2,
		ST_M2,
		ST_WB,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture input sample
		logic mem_rd;   // read state memories of current slot
		logic coef_rd;  // read coefficient of current tap
		logic mul;      // multiply coefficient by x or y
		logic mul_y;    // multiplier operand is y instead of x
		tap_t tap;
		logic acc_clr;  // acc <= product (first term)
		logic acc_add;  // acc += product
		logic acc_sub;  // acc -= product
		logic add_m1;   // acc += m1 << 10
		logic add_m2;   // acc += m2 << 10
		logic make_y;   // round and saturate acc into y
		logic make_m1;  // new m1 from acc
		logic make_m2;  // new m2 from acc
		logic mem_wr;   // write new m1/m2
		logic adv;      // x <= y
	} cmd_t;

	function automatic logic signed [SampleW-1:0] sat_y(input logic signed [AccW-1:0] v);
		logic signed [AccW-1:0] r;
		r = (v + (AccW'(1) <<< 26)) >>> 27;
		if (r > AccW'(signed'((1 <<< 23) - 1)))
			return {1'b0, {(SampleW-1){1'b1}}};
		else if (r < -AccW'(signed'(1 <<< 23)))
			return {1'b1, {(SampleW-1){1'b0}}};
		return r[SampleW-1:0];
	endfunction

	function automatic logic signed [MemW-1:0] sat_m(input logic signed [AccW-1:0] v);
		logic signed [AccW-1:0] r;
		r = v >>> 10;
		if (r[AccW-1:MemW-1] != {(AccW-MemW+1){r[AccW-1]}})
			return r[AccW-1] ? {1'b1, {(MemW-1){1'b0}}} : {1'b0, {(MemW-1){1'b1}}};
		return r[MemW-1:0];
	endfunction

endpackage

[hdl/bqc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_ctrl
// Sequencer: walks stages and issues the five products of each stage.
// ----------------------------------------------------------------------------
module bqc_ctrl
	import bqc_pkg::*;
#(
	parameter int MAX_STAGES = 8,
	parameter int CHANNELS   = 8,
	parameter int StgW       = 3
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [ChanW-1:0] in_chan,
	output logic           out_valid,
	input  logic           out_ready,
	input  logic [3:0]     stage_count,
	input  logic [7:0]     stage_bypass,
	output logic [StgW-1:0] stage,
	output cmd_t           cmd
);

	state_t state_q, state_d;
	logic [StgW-1:0] stage_q, stage_d;
	logic [4:0] nstg;
	logic [4:0] last_q, last_d;
	logic       skip;
	logic [4:0] next_stage;
	logic       chan_ok;
	logic [4:0] cur;

	assign stage = stage_q;
	assign cur = 5'(stage_q);
	assign nstg = (5'(stage_count) > 5'(MAX_STAGES)) ? 5'(MAX_STAGES) : 5'(stage_count);
	assign chan_ok = (32'(in_chan) < 32'(CHANNELS));
	assign skip = (cur < 5'd8) && stage_bypass[cur[2:0]];
	assign next_stage = cur + 5'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stage_q <= '0;
			last_q  <= '0;
		end else begin
			state_q <= state_d;
			stage_q <= stage_d;
			last_q  <= last_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		stage_d   = stage_q;
		last_d    = last_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					stage_d  = '0;
					last_d   = chan_ok ? nstg : 5'd0;
					state_d  = ST_SETUP;
				end
			end
			ST_SETUP: begin
				if (cur >= last_q)
					state_d = ST_OUT;
				else if (skip) begin
					if (next_stage >= last_q)
						state_d = ST_OUT;
					else
						stage_d = StgW'(next_stage);
				end else
					state_d = ST_RD;
			end
			ST_RD: begin
				cmd.mem_rd  = 1'b1;
				cmd.coef_rd = 1'b1;
				cmd.tap     = TAP_B0;
				state_d     = ST_B0;
			end
			ST_B0: begin
				cmd.mul     = 1'b1;
				cmd.tap     = TAP_B0;
				cmd.coef_rd = 1'b1;
				state_d     = ST_Y;
			end
			ST_Y: begin
				cmd.acc_clr = 1'b1;
				cmd.add_m1  = 1'b1;
				cmd.make_y  = 1'b1;
				cmd.tap     = TAP_B1;
				cmd.coef_rd = 1'b1;
				state_d     = ST_B1;
			end
			ST_B1: begin
				// b1*x now; fetch a1 for the next product
				cmd.mul     = 1'b1;
				cmd.tap     = TAP_A1;
				cmd.coef_rd = 1'b1;
				state_d     = ST_A1;
			end
			ST_A1: begin
				cmd.acc_clr = 1'b1;
				cmd.add_m2  = 1'b1;
				cmd.mul     = 1'b1;
				cmd.mul_y   = 1'b1;
				cmd.tap     = TAP_A1;
				cmd.coef_rd = 1'b1;
				state_d     = ST_M1;
			end
			ST_M1: begin
				cmd.acc_sub = 1'b1;
				cmd.make_m1 = 1'b1;
				cmd.tap     = TAP_B2;
				cmd.coef_rd = 1'b1;
				state_d     = ST_B2;
			end
			ST_B2: begin
				// b2*x now; fetch a2 for the next product
				cmd.mul     = 1'b1;
				cmd.tap     = TAP_A2;
				cmd.coef_rd = 1'b1;
				state_d     = ST_A2;
			end
			ST_A2: begin
				cmd.acc_clr = 1'b1;
				cmd.mul     = 1'b1;
				cmd.mul_y   = 1'b1;
				cmd.tap     = TAP_A2;
				state_d     = ST_M2;
			end
			ST_M2: begin
				cmd.acc_sub = 1'b1;
				cmd.make_m2 = 1'b1;
				state_d     = ST_WB;
			end
			ST_WB: begin
				cmd.mem_wr = 1'b1;
				cmd.adv    = 1'b1;
				if (next_stage >= last_q)
					state_d = ST_OUT;
				else begin
					stage_d = StgW'(next_stage);
					state_d = ST_SETUP;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[hdl/bqc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_dp
// Datapath: coefficient table, state memories, shared multiplier, accumulator.
// ----------------------------------------------------------------------------
module bqc_dp
	import bqc_pkg::*;
#(
	parameter int MAX_STAGES = 8,
	parameter int CHANNELS   = 8,
	parameter int StgW       = 3,
	parameter int SlotW      = 6,
	parameter int CoefAW     = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	input  logic [StgW-1:0]           stage,
	input  logic signed [SampleW-1:0] in_sample,
	input  logic [ChanW-1:0]          in_chan,
	input  logic                      coef_we,
	input  logic [5:0]                coef_index,
	input  logic signed [CoefW-1:0]   coef_wdata,
	output logic signed [SampleW-1:0] out_sample,
	output logic [ChanW-1:0]          out_chan
);

	localparam int CoefN = MAX_STAGES * 5;
	localparam int MemN  = CHANNELS * MAX_STAGES;

	logic signed [CoefW-1:0] coef_mem [CoefN];
	logic [CoefN-1:0]        coef_vld_q;
	logic signed [MemW-1:0]  m1_mem [MemN];
	logic signed [MemW-1:0]  m2_mem [MemN];
	logic [MemN-1:0]         mem_vld_q;

	logic signed [SampleW-1:0] x_q, y_q;
	logic [ChanW-1:0]          ch_q;
	logic signed [CoefW-1:0]   coef_q;
	logic signed [MemW-1:0]    m1_q, m2_q, m1n_q, m2n_q;
	logic                      m_vld_q;
	logic signed [ProdW-1:0]   prod_q;
	logic signed [AccW-1:0]    acc_q, acc_d;
	logic [SlotW-1:0]          slot;
	logic [CoefAW-1:0]         caddr;
	logic signed [SampleW-1:0] mop;
	logic                      rd_vld;

	assign slot  = SlotW'(32'(ch_q) * MAX_STAGES + 32'(stage));
	assign caddr = CoefAW'(32'(stage) * 5 + 32'(cmd.tap));
	assign mop   = cmd.mul_y ? y_q : x_q;
	assign out_sample = x_q;
	assign out_chan   = ch_q;

	// coefficient table with per-entry valid bits
	always_ff @(posedge clk) begin
		if (coef_we && 32'(coef_index) < CoefN)
			coef_mem[CoefAW'(coef_index)] <= coef_wdata;
		if (cmd.coef_rd)
			coef_q <= coef_vld_q[caddr] ? coef_mem[caddr] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
			mem_vld_q  <= '0;
			m_vld_q    <= 1'b0;
		end else begin
			if (coef_we && 32'(coef_index) < CoefN)
				coef_vld_q[CoefAW'(coef_index)] <= 1'b1;
			if (cmd.mem_wr)
				mem_vld_q[slot] <= 1'b1;
			if (cmd.mem_rd)
				m_vld_q <= mem_vld_q[slot];
		end
	end

	// state memories: one read and one write port each
	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			m1_q <= m1_mem[slot];
			m2_q <= m2_mem[slot];
		end
		if (cmd.mem_wr) begin
			m1_mem[slot] <= m1n_q;
			m2_mem[slot] <= m2n_q;
		end
	end

	assign rd_vld = m_vld_q;

	always_comb begin
		acc_d = acc_q;
		if (cmd.acc_clr)
			acc_d = AccW'(prod_q);
		else if (cmd.acc_sub)
			acc_d = acc_q - AccW'(prod_q);
		if (cmd.add_m1 && rd_vld)
			acc_d = acc_d + (AccW'(m1_q) <<< 10);
		if (cmd.add_m2 && rd_vld)
			acc_d = acc_d + (AccW'(m2_q) <<< 10);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q  <= in_sample;
			ch_q <= in_chan;
		end
		if (cmd.mul)
			prod_q <= ProdW'(coef_q * mop);
		// B1 product must also count: add it into acc at A1 step
		if (cmd.acc_clr || cmd.acc_sub || cmd.add_m1 || cmd.add_m2)
			acc_q <= acc_d;
		if (cmd.make_y)
			y_q <= sat_y(acc_d);
		if (cmd.make_m1)
			m1n_q <= sat_m(acc_d);
		if (cmd.make_m2)
			m2n_q <= sat_m(acc_d);
		if (cmd.adv)
			x_q <= y_q;
	end

endmodule

[hdl/biquad_cascade_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_cascade_filter
// Multichannel cascade of transposed direct form II biquads, one shared MAC.
// ----------------------------------------------------------------------------
// Latency: after the input transfer, each active stage runs SETUP, RD, B0, Y,
//   B1, A1, M1, B2, A2, M2 and WB, each bypassed stage only SETUP, then OUT.
// Throughput: one sample in flight; the next input is taken the cycle after the
//   output transfer, and the single multiplier issues the five products of
//   each active stage in turn. An output stall holds the block in OUT.
// Reset: arst_n clears the config registers, control state, and valid bits of
//   the coefficient table and state memories, so both read as zero until written.
// ----------------------------------------------------------------------------
module biquad_cascade_filter
	import bqc_pkg::*;
#(
	parameter int MAX_STAGES = 8,
	parameter int CHANNELS   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB config
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [23:0] in_sample, [26:24] channel
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [23:0] out_sample, [26:24] out_channel
);

	localparam int StgW   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int SlotW  = (CHANNELS * MAX_STAGES > 1) ? $clog2(CHANNELS * MAX_STAGES) : 1;
	localparam int CoefAW = $clog2(MAX_STAGES * 5);

	logic [3:0]  stage_count_q;
	logic [7:0]  stage_bypass_q;
	logic [5:0]  coef_index_q;
	logic [31:0] coef_value_q;
	logic        wr;
	logic [1:0]  reg_sel;
	cmd_t        cmd;
	logic [StgW-1:0] stage;
	logic signed [SampleW-1:0] out_sample;
	logic [ChanW-1:0] out_chan;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite;
	assign reg_sel = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_count_q  <= '0;
			stage_bypass_q <= '0;
			coef_index_q   <= '0;
			coef_value_q   <= '0;
		end else if (wr) begin
			case (reg_sel)
				REG_STAGE_COUNT:  stage_count_q  <= pwdata[3:0];
				REG_STAGE_BYPASS: stage_bypass_q <= pwdata[7:0];
				REG_COEF_INDEX:   coef_index_q   <= pwdata[5:0];
				REG_COEF_VALUE:   coef_value_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_STAGE_COUNT:  prdata = {28'd0, stage_count_q};
			REG_STAGE_BYPASS: prdata = {24'd0, stage_bypass_q};
			REG_COEF_INDEX:   prdata = {26'd0, coef_index_q};
			REG_COEF_VALUE:   prdata = coef_value_q;
			default:          prdata = '0;
		endcase
	end

	bqc_ctrl #(.MAX_STAGES(MAX_STAGES), .CHANNELS(CHANNELS), .StgW(StgW)) u_ctrl (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready), .in_chan(s_tdata[26:24]),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.stage_count(stage_count_q), .stage_bypass(stage_bypass_q),
		.stage, .cmd
	);

	bqc_dp #(.MAX_STAGES(MAX_STAGES), .CHANNELS(CHANNELS), .StgW(StgW),
		.SlotW(SlotW), .CoefAW(CoefAW)) u_dp (
		.clk, .arst_n, .cmd, .stage,
		.in_sample(s_tdata[23:0]), .in_chan(s_tdata[26:24]),
		.coef_we(wr && reg_sel == REG_COEF_VALUE),
		.coef_index(coef_index_q), .coef_wdata(pwdata),
		.out_sample, .out_chan
	);

	assign m_tdata = {5'd0, out_chan, out_sample};

endmodule
